// ----- hw/rtl/ldagc_pkg.sv -----
package ldagc_pkg;

	localparam int SAMPLE_BITS_DEF    = 16;
	localparam int LOG_TABLE_BITS_DEF = 6;

	localparam int GAIN_W    = 16;  // Q6.10 log2 gain
	localparam int LOG_FRAC  = 10;
	localparam int LOG_W     = 17;  // log2|x| in Q7.10
	localparam int ERR_W     = 18;
	localparam int EXP_W     = 16;  // 2^(k/N) entry, unsigned Q1.15
	localparam int LOGT_W    = 11;  // log2(1+m/N) entry, Q0.10
	localparam int RATE_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int FIFO_DEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_LOG_GAIN    = 2'd0,
		REG_MAX_LOG_GAIN        = 2'd1,
		REG_REFERENCE_LOG_LEVEL = 2'd2,
		REG_LOOP_RATE           = 2'd3
	} cfg_reg_t;

	localparam logic signed [GAIN_W-1:0] INITIAL_LOG_GAIN_RST    = 16'sd0;
	localparam logic signed [GAIN_W-1:0] MAX_LOG_GAIN_RST        = 16'sd10240;
	localparam logic signed [GAIN_W-1:0] REFERENCE_LOG_LEVEL_RST = -16'sd1024;
	localparam logic [RATE_W-1:0]        LOOP_RATE_RST           = 16'd655;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_SHIFT,
		BK_UPDATE
	} back_state_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = val;
		res = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// 2^(k/2^ltb) in Q1.15, built from repeated square roots of 2 in Q2.30
	function automatic logic [EXP_W-1:0] exp_entry(input int ltb, input int k);
		logic [63:0] roots [11];
		logic [63:0] acc;
		roots[0] = 64'd1 << 31;
		for (int j = 1; j <= 10; j++) begin
			roots[j] = (j <= ltb) ? isqrt64(roots[j-1] << 30) : 64'd0;
		end
		acc = 64'd1 << 30;
		for (int b = 0; b < 10; b++) begin
			if (b < ltb && ((k >> b) & 1) != 0) begin
				acc = (acc * roots[ltb-b] + (64'd1 << 29)) >> 30;
			end
		end
		acc = (acc + (64'd1 << 14)) >> 15;
		return acc[EXP_W-1:0];
	endfunction

	// log2(1 + k/2^ltb) in Q0.10 by repeated squaring
	function automatic logic [LOGT_W-1:0] log_entry(input int ltb, input int k);
		logic [63:0] v;
		logic [11:0] r;
		v = 64'(k + (1 << ltb)) << (30 - ltb);
		r = '0;
		for (int b = 0; b < 11; b++) begin
			v = (v * v + (64'd1 << 29)) >> 30;
			r = r << 1;
			if (v >= (64'd1 << 31)) begin
				v = v >> 1;
				r[0] = 1'b1;
			end
		end
		r = r + 12'd1;
		return r[LOGT_W:1];
	endfunction

endpackage

// ----- hw/rtl/ldagc_fifo.sv -----
module ldagc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = ldagc_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/ldagc_front.sv -----
module ldagc_front #(
	parameter int SAMPLE_BITS    = ldagc_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = ldagc_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,
	output logic                                 full,
	output logic                                 q_push,
	output logic [SAMPLE_BITS+ldagc_pkg::LOG_W:0] q_word,
	input  logic                                 q_full
);

	localparam int TBL_N = 1 << LOG_TABLE_BITS;
	localparam int POS_W = $clog2(SAMPLE_BITS);
	localparam int EXT_W = SAMPLE_BITS + LOG_TABLE_BITS;
	localparam int LOG_W = ldagc_pkg::LOG_W;

	logic [ldagc_pkg::LOGT_W-1:0] log_rom [TBL_N];

	for (genvar k = 0; k < TBL_N; k++) begin : g_log_rom
		localparam logic [ldagc_pkg::LOGT_W-1:0] ENTRY = ldagc_pkg::log_entry(LOG_TABLE_BITS, k);
		assign log_rom[k] = ENTRY;
	end

	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          valid_s1;
	logic                          accept;
	logic                          neg;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [POS_W-1:0]              pos;
	logic [EXT_W-1:0]              ext;
	logic [LOG_TABLE_BITS-1:0]     idx;
	logic signed [LOG_W-1:0]       pos_ext;
	logic signed [LOG_W-1:0]       logv;

	assign full   = valid_s1 & q_full;
	assign accept = push & ~full;
	assign q_push = valid_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_in;
		end
	end

	// magnitude, leading one and table index for log2|x|
	always_comb begin
		neg = sample_s1[SAMPLE_BITS-1];
		mag = neg ? SAMPLE_BITS'(-sample_s1) : sample_s1;
		pos = '0;
		for (int i = 1; i < SAMPLE_BITS; i++) begin
			if (mag[i]) begin
				pos = POS_W'(i);
			end
		end
		ext     = {mag, {LOG_TABLE_BITS{1'b0}}};
		idx     = LOG_TABLE_BITS'(ext >> pos);
		pos_ext = LOG_W'(pos) - LOG_W'(SAMPLE_BITS - 1);
		logv    = (pos_ext <<< ldagc_pkg::LOG_FRAC) + LOG_W'(log_rom[idx]);
	end

	assign q_word = {neg, logv, mag};

endmodule

// ----- hw/rtl/ldagc_back.sv -----
module ldagc_back #(
	parameter int SAMPLE_BITS    = ldagc_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = ldagc_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_we,
	input  logic [ldagc_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [ldagc_pkg::GAIN_W-1:0]                 cfg_wdata,
	input  logic                                         q_empty,
	output logic                                         q_pop,
	input  logic [SAMPLE_BITS+ldagc_pkg::LOG_W:0]         q_word,
	input  logic                                         o_full,
	output logic                                         o_push,
	output logic [SAMPLE_BITS+ldagc_pkg::GAIN_W-1:0]      o_word
);

	localparam int GAIN_W  = ldagc_pkg::GAIN_W;
	localparam int LOG_W   = ldagc_pkg::LOG_W;
	localparam int ERR_W   = ldagc_pkg::ERR_W;
	localparam int RATE_W  = ldagc_pkg::RATE_W;
	localparam int TBL_N   = 1 << LOG_TABLE_BITS;
	localparam int PROD_W  = SAMPLE_BITS + ldagc_pkg::EXP_W;
	localparam int SHW     = PROD_W + 16;   // room for the largest left shift
	localparam int MUL_W   = ERR_W + RATE_W + 1;
	localparam int STEP_W  = ERR_W + 1;
	localparam int IP_W    = GAIN_W - ldagc_pkg::LOG_FRAC;
	localparam int SH_W    = IP_W + 1;
	localparam logic signed [STEP_W-1:0] GAIN_MIN = -(STEP_W'(1) <<< (GAIN_W - 1));

	logic [ldagc_pkg::EXP_W-1:0] exp_rom [TBL_N];

	for (genvar k = 0; k < TBL_N; k++) begin : g_exp_rom
		localparam logic [ldagc_pkg::EXP_W-1:0] ENTRY = ldagc_pkg::exp_entry(LOG_TABLE_BITS, k);
		assign exp_rom[k] = ENTRY;
	end

	ldagc_pkg::back_state_t state_q, state_d;

	logic                          neg_q;
	logic signed [LOG_W-1:0]       logv_q;
	logic [SAMPLE_BITS-1:0]        mag_q;
	logic [PROD_W-1:0]             prod_q;
	logic signed [ERR_W-1:0]       err_q;
	logic signed [MUL_W-1:0]       mul_q;
	logic [SAMPLE_BITS-1:0]        res_q;
	logic signed [GAIN_W-1:0]      gain_q;
	logic signed [GAIN_W-1:0]      max_q;
	logic signed [GAIN_W-1:0]      ref_q;
	logic [RATE_W-1:0]             rate_q;

	logic [LOG_TABLE_BITS-1:0]     exp_idx;
	logic signed [IP_W-1:0]        ip;
	logic signed [SH_W-1:0]        sh;
	logic [4:0]                    lsh;
	logic [SH_W-2:0]               rsh;
	logic [SHW-1:0]                prod_w;
	logic [SHW-1:0]                tmp;
	logic [SHW-1:0]                wide;
	logic [SHW-1:0]                lim;
	logic [SHW-1:0]                sat;
	logic [SAMPLE_BITS-1:0]        shaped;
	logic signed [RATE_W:0]        rate_s;
	logic signed [MUL_W-1:0]       sum;
	logic signed [STEP_W-1:0]      step;
	logic signed [STEP_W-1:0]      ng;
	logic signed [GAIN_W-1:0]      gain_next;

	// sequencer: pop, exp multiply, shift + loop multiply, gain write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldagc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		o_push  = 1'b0;
		case (state_q)
			ldagc_pkg::BK_IDLE: begin
				if (!q_empty && !o_full) begin
					q_pop   = 1'b1;
					state_d = ldagc_pkg::BK_MUL;
				end
			end
			ldagc_pkg::BK_MUL: begin
				state_d = ldagc_pkg::BK_SHIFT;
			end
			ldagc_pkg::BK_SHIFT: begin
				state_d = ldagc_pkg::BK_UPDATE;
			end
			ldagc_pkg::BK_UPDATE: begin
				o_push  = 1'b1;
				state_d = ldagc_pkg::BK_IDLE;
			end
			default: begin
				state_d = ldagc_pkg::BK_IDLE;
			end
		endcase
	end

	// output scaling: |x| * 2^frac, then shift by integer part - 15
	always_comb begin
		exp_idx = gain_q[ldagc_pkg::LOG_FRAC-1 -: LOG_TABLE_BITS];
		ip      = gain_q[GAIN_W-1:ldagc_pkg::LOG_FRAC];
		sh      = {ip[IP_W-1], ip} - SH_W'(15);
		lsh     = sh[4:0];
		rsh     = (SH_W-1)'(-sh);
		prod_w  = SHW'(prod_q);
		tmp     = prod_w >> (rsh - 1'b1);
		if (sh > 0) begin
			wide = prod_w << lsh;
		end else if (sh == 0) begin
			wide = prod_w;
		end else begin
			// round half away from zero on the magnitude
			wide = (tmp + SHW'(1)) >> 1;
		end
		lim    = neg_q ? (SHW'(1) << (SAMPLE_BITS - 1))
		               : ((SHW'(1) << (SAMPLE_BITS - 1)) - SHW'(1));
		sat    = (wide > lim) ? lim : wide;
		shaped = neg_q ? ({SAMPLE_BITS{1'b0}} - sat[SAMPLE_BITS-1:0]) : sat[SAMPLE_BITS-1:0];
	end

	// loop update: g += floor((err*rate + 2^15) / 2^16), clamped
	always_comb begin
		rate_s = {1'b0, rate_q};
		sum    = mul_q + MUL_W'(32768);
		step   = STEP_W'(sum >>> 16);
		ng     = STEP_W'(gain_q) + step;
		if (mag_q == '0) begin
			gain_next = max_q;  // zero input: error is unbounded
		end else if (ng > STEP_W'(max_q)) begin
			gain_next = max_q;
		end else if (ng < GAIN_MIN) begin
			gain_next = GAIN_MIN[GAIN_W-1:0];
		end else begin
			gain_next = ng[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			{neg_q, logv_q, mag_q} <= q_word;
		end
		if (state_q == ldagc_pkg::BK_MUL) begin
			prod_q <= mag_q * exp_rom[exp_idx];
			err_q  <= ERR_W'(ref_q) - ERR_W'(logv_q) - ERR_W'(gain_q);
		end
		if (state_q == ldagc_pkg::BK_SHIFT) begin
			res_q <= shaped;
			mul_q <= err_q * rate_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ldagc_pkg::INITIAL_LOG_GAIN_RST;
			max_q  <= ldagc_pkg::MAX_LOG_GAIN_RST;
			ref_q  <= ldagc_pkg::REFERENCE_LOG_LEVEL_RST;
			rate_q <= ldagc_pkg::LOOP_RATE_RST;
		end else if (cfg_we) begin
			case (ldagc_pkg::cfg_reg_t'(cfg_index))
				ldagc_pkg::REG_INITIAL_LOG_GAIN:    gain_q <= cfg_wdata;
				ldagc_pkg::REG_MAX_LOG_GAIN:        max_q  <= cfg_wdata;
				ldagc_pkg::REG_REFERENCE_LOG_LEVEL: ref_q  <= cfg_wdata;
				ldagc_pkg::REG_LOOP_RATE:           rate_q <= cfg_wdata;
				default: begin
				end
			endcase
		end else if (o_push) begin
			gain_q <= gain_next;
		end
	end

	// gain_q still holds the gain applied to this word
	assign o_word = {gain_q, res_q};

endmodule

// ----- hw/rtl/log_domain_audio_agc.sv -----
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+-------------------------------------
// input    | in  | push / full        | sample_in  (signed Q1.15)
// result   | out | empty / pop        | sample_out (signed Q1.15), gain_used (Q6.10)
// config   | in  | cfg_we, cfg_index  | cfg_wdata  (16 bit)
//
// The gain unit steps through pop, exp multiply, shift and loop multiply, and
// gain write for each word; the gain feedback through it sets the sustained rate.
// A word passes the input stage register, middle queue, gain unit and output queue.
// arst_n clears the queues and loads the register reset values; no clearing pass.
// A stalled result side fills the output queue, then the middle queue, then
// the input stage, and only then raises full.
module log_domain_audio_agc #(
	parameter int SAMPLE_BITS    = ldagc_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = ldagc_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	output logic signed [ldagc_pkg::GAIN_W-1:0] gain_used,
	input  logic                                cfg_we,
	input  logic [ldagc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ldagc_pkg::GAIN_W-1:0]        cfg_wdata
);

	localparam int MID_W = SAMPLE_BITS + ldagc_pkg::LOG_W + 1;
	localparam int OUT_W = SAMPLE_BITS + ldagc_pkg::GAIN_W;

	logic             mid_push;
	logic [MID_W-1:0] mid_wdata;
	logic             mid_full;
	logic             mid_pop;
	logic [MID_W-1:0] mid_rdata;
	logic             mid_empty;
	logic             out_push;
	logic [OUT_W-1:0] out_wdata;
	logic             out_full;
	logic [OUT_W-1:0] out_rdata;

	ldagc_front #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample_in (sample_in),
		.full      (full),
		.q_push    (mid_push),
		.q_word    (mid_wdata),
		.q_full    (mid_full)
	);

	ldagc_fifo #(
		.WIDTH (MID_W),
		.DEPTH (ldagc_pkg::FIFO_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	ldagc_back #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_empty   (mid_empty),
		.q_pop     (mid_pop),
		.q_word    (mid_rdata),
		.o_full    (out_full),
		.o_push    (out_push),
		.o_word    (out_wdata)
	);

	ldagc_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (ldagc_pkg::FIFO_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wdata),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (out_rdata),
		.empty   (empty)
	);

	assign sample_out = out_rdata[SAMPLE_BITS-1:0];
	assign gain_used  = out_rdata[OUT_W-1:SAMPLE_BITS];

endmodule

// ----- hw/rtl/ldagc_checker.sv -----
module ldagc_checker #(
	parameter int SAMPLE_BITS = ldagc_pkg::SAMPLE_BITS_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                push,
	input logic                                full,
	input logic                                empty,
	input logic                                pop,
	input logic signed [SAMPLE_BITS-1:0]       sample_out,
	input logic signed [ldagc_pkg::GAIN_W-1:0] gain_used
);

	// input stage + middle queue + gain unit + output queue
	localparam int CAP   = 2 * ldagc_pkg::FIFO_DEPTH + 2;
	localparam int CNT_W = $clog2(CAP + 2);

	logic [CNT_W-1:0] cnt_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = push & ~full;
	assign out_acc = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAP))
		else $error("more words in flight than the block can hold");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> cnt_q != '0)
		else $error("result shown with no word outstanding");

	a_full_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cnt_q >= CNT_W'(ldagc_pkg::FIFO_DEPTH + 1))
		else $error("full raised before the input side is backed up");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(sample_out) && $stable(gain_used))
		else $error("stalled result changed");

endmodule

bind log_domain_audio_agc ldagc_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_ldagc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.sample_out (sample_out),
	.gain_used  (gain_used)
);

// ----- sim/log_domain_audio_agc_chk.sv -----
module log_domain_audio_agc_chk (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         push,
	input  logic                                         full,
	input  logic signed [ldagc_pkg::SAMPLE_BITS_DEF-1:0] sample_in,
	input  logic                                         empty,
	input  logic                                         pop,
	input  logic signed [ldagc_pkg::SAMPLE_BITS_DEF-1:0] sample_out,
	input  logic signed [ldagc_pkg::GAIN_W-1:0]          gain_used,
	input  logic                                         cfg_we,
	input  logic [ldagc_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [ldagc_pkg::GAIN_W-1:0]                 cfg_wdata,
	output int                                           fail_count,
	output int                                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW       = ldagc_pkg::SAMPLE_BITS_DEF;
	localparam int LTB      = ldagc_pkg::LOG_TABLE_BITS_DEF;
	localparam int N        = 1 << LTB;
	localparam int GAIN_W   = ldagc_pkg::GAIN_W;
	localparam int RATE_W   = ldagc_pkg::RATE_W;
	localparam int LOG_FRAC = ldagc_pkg::LOG_FRAC;

	typedef struct {
		logic signed [SW-1:0]     smp;
		logic signed [GAIN_W-1:0] gain;
	} agc_word_t;

	int unsigned exp_lut [N];
	int unsigned log_lut [N];

	logic signed [GAIN_W-1:0] gain_st;
	logic signed [GAIN_W-1:0] gain_ceil;
	logic signed [GAIN_W-1:0] ref_lvl;
	logic [RATE_W-1:0]        loop_rate;

	agc_word_t gain_words_q [$];

	initial fail_count = 0;
	initial pending = 0;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	// exp table: 2^(k/N) in Q1.15, log table: log2(1+k/N) in Q0.10
	initial begin
		longint unsigned root [LTB+1];
		longint unsigned acc, v;
		int unsigned r;
		root[0] = 64'd1 << 31;
		for (int j = 1; j <= LTB; j++)
			root[j] = int_sqrt(root[j-1] << 30);
		for (int k = 0; k < N; k++) begin
			acc = 64'd1 << 30;
			for (int b = 0; b < LTB; b++) begin
				if (((k >> b) & 1) != 0)
					acc = (acc * root[LTB-b] + (64'd1 << 29)) >> 30;
			end
			exp_lut[k] = int'((acc + (64'd1 << 14)) >> 15);
		end
		for (int k = 0; k < N; k++) begin
			v = longint'(N + k) << (30 - LTB);
			r = 0;
			for (int b = 0; b < 11; b++) begin
				v = (v * v + (64'd1 << 29)) >> 30;
				r = r << 1;
				if (v >= (64'd1 << 31)) begin
					v >>= 1;
					r |= 1;
				end
			end
			log_lut[k] = (r + 1) >> 1;
		end
	end

	function automatic logic [SW-1:0] scaled_sample(input logic signed [SW-1:0] x,
			input logic signed [GAIN_W-1:0] g);
		longint unsigned mag, lim;
		logic [63:0] res;
		int ip, sh, s;
		int unsigned idx;
		bit neg;
		neg = x < 0;
		mag = neg ? -longint'(x) : longint'(x);
		ip = int'(g) >>> LOG_FRAC;
		idx = (int'(g) & 1023) >> (LOG_FRAC - LTB);
		sh = ip - 15;
		mag = mag * exp_lut[idx];
		if (sh > 0) begin
			if (mag != 0 && (sh >= 40 || (mag >> (40 - sh)) != 0))
				mag = 64'd1 << 40;
			else
				mag = mag << sh;
		end else if (sh < 0) begin
			s = -sh;
			// round half away from zero on the magnitude
			mag = (mag + (64'd1 << (s - 1))) >> s;
		end
		lim = neg ? (64'd1 << (SW - 1)) : ((64'd1 << (SW - 1)) - 1);
		if (mag > lim)
			mag = lim;
		res = neg ? (64'd0 - mag) : mag;
		return res[SW-1:0];
	endfunction

	function automatic int log2_level(input longint unsigned mag);
		int p;
		int unsigned idx;
		p = 0;
		while (p < 63 && (mag >> (p + 1)) != 0)
			p++;
		if (p >= LTB)
			idx = int'(mag >> (p - LTB)) & (N - 1);
		else
			idx = int'(mag << (LTB - p)) & (N - 1);
		return (p - (SW - 1)) * 1024 + int'(log_lut[idx]);
	endfunction

	// output of this word, then the loop update of the gain
	function automatic agc_word_t predict_word(input logic signed [SW-1:0] x);
		agc_word_t w;
		longint unsigned mag;
		longint err, ng;
		w.smp = scaled_sample(x, gain_st);
		w.gain = gain_st;
		if (x == 0) begin
			gain_st = gain_ceil;
		end else begin
			mag = x < 0 ? -longint'(x) : longint'(x);
			err = longint'(ref_lvl) - (longint'(log2_level(mag)) + longint'(gain_st));
			ng = longint'(gain_st) + ((err * longint'(loop_rate) + 32768) >>> 16);
			if (ng > longint'(gain_ceil))
				ng = longint'(gain_ceil);
			if (ng < -32768)
				ng = -32768;
			gain_st = 16'(ng);
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		agc_word_t w;
		if (!arst_n) begin
			gain_st = ldagc_pkg::INITIAL_LOG_GAIN_RST;
			gain_ceil = ldagc_pkg::MAX_LOG_GAIN_RST;
			ref_lvl = ldagc_pkg::REFERENCE_LOG_LEVEL_RST;
			loop_rate = ldagc_pkg::LOOP_RATE_RST;
			gain_words_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (ldagc_pkg::cfg_reg_t'(cfg_index))
					ldagc_pkg::REG_INITIAL_LOG_GAIN: gain_st = cfg_wdata;
					ldagc_pkg::REG_MAX_LOG_GAIN: gain_ceil = cfg_wdata;
					ldagc_pkg::REG_REFERENCE_LOG_LEVEL: ref_lvl = cfg_wdata;
					ldagc_pkg::REG_LOOP_RATE: loop_rate = cfg_wdata;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (gain_words_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected word: sample_out %0d gain_used %0d",
							sample_out, gain_used);
					fail_count++;
				end else begin
					w = gain_words_q.pop_front();
					if (sample_out !== w.smp || gain_used !== w.gain) begin
						if (fail_count < 10) begin
							$display("mismatch at %0t: sample_out exp %0d got %0d,",
								$realtime, w.smp, sample_out);
							$display("  gain_used exp %0d got %0d", w.gain, gain_used);
						end
						fail_count++;
					end
				end
			end
			if (push && !full)
				gain_words_q.push_back(predict_word(sample_in));
			pending = gain_words_q.size();
		end
	end

endmodule

// ----- sim/log_domain_audio_agc_tb.sv -----
module log_domain_audio_agc_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW          = ldagc_pkg::SAMPLE_BITS_DEF;
	localparam int GAIN_W      = ldagc_pkg::GAIN_W;
	localparam int CFG_IDX_W   = ldagc_pkg::CFG_IDX_W;
	localparam int PHASE_WORDS = 166;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE      = 10;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic signed [SW-1:0]     sample_in = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [SW-1:0]     sample_out;
	logic signed [GAIN_W-1:0] gain_used;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = ldagc_pkg::REG_INITIAL_LOG_GAIN;
	logic [GAIN_W-1:0]        cfg_wdata = '0;

	int fail_count;
	int pending;
	int hold_token = 0;
	int idle_cycles = 0;

	logic signed [SW-1:0] corner_samples [22] = '{
		16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384,
		16'sd21845, -16'sd21846, 16'sd0, 16'sd2, 16'sd3, 16'sd127, -16'sd128,
		16'sd100, -16'sd100, -16'sd32768, 16'sd32767, 16'sd0, 16'sd64, 16'sd65, -16'sd32767
	};

	always #6 clk = ~clk;

	log_domain_audio_agc i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.gain_used  (gain_used),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	log_domain_audio_agc_chk i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.gain_used  (gain_used),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic signed [SW-1:0] rand_sample();
		logic signed [SW-1:0] v;
		int pick;
		pick = $urandom_range(0, 99);
		v = SW'($urandom);
		if (pick < 4) begin
			v = '0;
		end else if (pick < 10) begin
			case ($urandom_range(0, 3))
				0: v = 16'sd32767;
				1: v = -16'sd32768;
				2: v = 16'sd1;
				default: v = -16'sd1;
			endcase
		end else if (pick >= 50) begin
			// quieter material: spread over the whole log range
			v = v >>> $urandom_range(0, 14);
		end
		return v;
	endfunction

	task automatic send_sample(input logic signed [SW-1:0] v);
		push <= 1'b1;
		sample_in <= v;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic run_samples(input int count);
		int left, burst, gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left)
				burst = left;
			repeat (burst)
				send_sample(rand_sample());
			left -= burst;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		push <= 1'b0;
	endtask

	// all registers, gain load last so the loop starts from it
	task automatic load_config(input logic [GAIN_W-1:0] init_g, input logic [GAIN_W-1:0] max_g,
			input logic [GAIN_W-1:0] ref_l, input logic [GAIN_W-1:0] rate);
		cfg_we <= 1'b1;
		cfg_index <= ldagc_pkg::REG_MAX_LOG_GAIN;
		cfg_wdata <= max_g;
		@(posedge clk);
		cfg_index <= ldagc_pkg::REG_REFERENCE_LOG_LEVEL;
		cfg_wdata <= ref_l;
		@(posedge clk);
		cfg_index <= ldagc_pkg::REG_LOOP_RATE;
		cfg_wdata <= rate;
		@(posedge clk);
		cfg_index <= ldagc_pkg::REG_INITIAL_LOG_GAIN;
		cfg_wdata <= init_g;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one edge first so the last accepted word is already counted
	task automatic wait_drained();
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// result side: random stall patterns, plus a long hold when requested
	initial begin
		int mode, len, seen_hold;
		seen_hold = 0;
		@(posedge arst_n);
		forever begin
			if (hold_token != seen_hold) begin
				seen_hold = hold_token;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 80);
			repeat (len) begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 7) == 0);
					default: pop <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero, full scale, most negative and small levels
		foreach (corner_samples[i])
			send_sample(corner_samples[i]);
		push <= 1'b0;
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_config(16'd0, 16'd10240, -16'sd1024, 16'd655);
				1: load_config(16'sd32767, 16'sd32767, 16'sd32767, 16'd65535);
				2: load_config(-16'sd32768, -16'sd32768, -16'sd32768, 16'd65535);
				3: load_config(-16'sd32768, 16'sd32767, -16'sd32768, 16'd0);
				4: load_config(16'd0, 16'd0, 16'd0, 16'd1);
				7: load_config(16'sd5120, 16'sd12288, -16'sd3072, 16'd8000);
				default: load_config(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			endcase
			// long receiver hold while words keep coming: fills the block
			if (ph == 0)
				hold_token <= hold_token + 1;
			run_samples(PHASE_WORDS);
			wait_drained();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
